// ===== src/gss_pkg.sv =====
// shared types and constants for goal seek steering
package gss_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int INDEX_BITS = 12;
	localparam int STEP_BITS = $clog2(CORDIC_STEPS + 1);
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 30;

	localparam logic [1:0] CMD_RANGE = 2'd0;
	localparam logic [1:0] CMD_HEADING = 2'd1;
	localparam logic [1:0] CMD_FIX = 2'd2;

	localparam logic [1:0] MODE_STEER = 2'd0;
	localparam logic [1:0] MODE_AVOID = 2'd1;
	localparam logic [1:0] MODE_GOAL = 2'd2;

	localparam logic [2:0] REG_GOAL_E = 3'd0;
	localparam logic [2:0] REG_GOAL_N = 3'd1;
	localparam logic [2:0] REG_SCAN_LEN = 3'd2;
	localparam logic [2:0] REG_MAX_RANGE = 3'd3;
	localparam logic [2:0] REG_FLOOR = 3'd4;
	localparam logic [2:0] REG_OBST = 3'd5;
	localparam logic [2:0] REG_RADIUS = 3'd6;
	localparam logic [2:0] REG_SLOWDOWN = 3'd7;

	localparam logic [14:0] SPEED_FULL = 15'd32767;
	localparam logic [14:0] SPEED_AVOID = 15'd3277;
	localparam logic signed [15:0] TURN_AVOID = 16'sd19661;
	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
	localparam logic [29:0] DIST_MAX = 30'h3FFFFFFF;

	typedef struct packed {
		logic [1:0] cmd;
		logic [15:0] range_mm;
		logic last_sample;
		logic signed [15:0] heading_deg;
		logic [26:0] easting_cm;
		logic [29:0] northing_cm;
	} in_item_t;

	typedef struct packed {
		logic [14:0] speed;
		logic signed [15:0] turn;
		logic [1:0] mode;
		logic [29:0] distance_cm;
	} out_item_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		case (i)
			5'd0: atan_bam = 32'd536870912;
			5'd1: atan_bam = 32'd316933406;
			5'd2: atan_bam = 32'd167458907;
			5'd3: atan_bam = 32'd85004756;
			5'd4: atan_bam = 32'd42667331;
			5'd5: atan_bam = 32'd21354465;
			5'd6: atan_bam = 32'd10680862;
			5'd7: atan_bam = 32'd5340245;
			5'd8: atan_bam = 32'd2670163;
			5'd9: atan_bam = 32'd1335087;
			5'd10: atan_bam = 32'd667544;
			5'd11: atan_bam = 32'd333772;
			5'd12: atan_bam = 32'd166886;
			5'd13: atan_bam = 32'd83443;
			5'd14: atan_bam = 32'd41722;
			5'd15: atan_bam = 32'd20861;
			5'd16: atan_bam = 32'd10430;
			5'd17: atan_bam = 32'd5215;
			5'd18: atan_bam = 32'd2608;
			5'd19: atan_bam = 32'd1304;
			5'd20: atan_bam = 32'd652;
			5'd21: atan_bam = 32'd326;
			5'd22: atan_bam = 32'd163;
			5'd23: atan_bam = 32'd81;
			5'd24: atan_bam = 32'd41;
			5'd25: atan_bam = 32'd20;
			5'd26: atan_bam = 32'd10;
			5'd27: atan_bam = 32'd5;
			5'd28: atan_bam = 32'd3;
			5'd29: atan_bam = 32'd1;
			5'd30: atan_bam = 32'd1;
			default: atan_bam = 32'd0;
		endcase
	endfunction
endpackage

// ===== src/goal_seek_steering_with_scan_avoid.sv =====
// goal seek steering with lidar scan obstacle avoidance
// range items can follow back to back; a heading item stalls input after acceptance through
// its 8 mod-360 reduction steps plus the angle conversion
// a position fix stalls input after acceptance through the pre-rotation, CORDIC_STEPS cordic
// steps, the gain product, the speed divider and the output stage, and also while a finished
// result waits for the previous one; reset restores register defaults
module goal_seek_steering_with_scan_avoid (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input gss_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output gss_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [gss_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input logic [gss_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import gss_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRE = 3'd1;
	localparam logic [2:0] ST_CORDIC = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_DIV = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;
	localparam logic [2:0] ST_HEAD = 3'd6;
	localparam logic [2:0] ST_HBAM = 3'd7;

	// 360*92, lifts any 16-bit heading to a nonnegative value with the same residue
	localparam logic [16:0] HEAD_LIFT = 17'd33120;
	// floor(2^32/360) and ceil(2^26/360)
	localparam logic [31:0] BAM_PER_DEG = 32'd11930464;
	localparam logic [34:0] RECIP_360 = 35'd186414;

	logic [2:0] state_q;
	logic [26:0] goal_e_q;
	logic [29:0] goal_n_q;
	logic [12:0] scan_len_q;
	logic [15:0] max_range_q, floor_q, obst_q, radius_q, slowdown_q;
	logic [31:0] head_bam_q;
	logic [15:0] wl_q, wr_q, lmin_q, rmin_q;
	logic obst_flag_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic signed [33:0] x_q, y_q;
	logic [31:0] z_q;
	logic [STEP_BITS-1:0] step_q;
	logic [63:0] acc_q;
	logic [1:0] mcnt_q;
	logic [29:0] dist_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [4:0] dcnt_q;
	logic [16:0] hred_q;
	logic [2:0] hcnt_q;
	out_item_t out_q;
	logic out_valid_q;

	logic accept;
	logic out_load;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// scan sample folded into the running side minima
	logic left_side, smp_ok;
	logic [15:0] smp_l, smp_r;
	always_comb begin
		left_side = 17'(idx_q) < 17'(scan_len_q >> 1);
		smp_ok = in_data.range_mm > floor_q;
		smp_l = wl_q;
		smp_r = wr_q;
		if (smp_ok && left_side && in_data.range_mm < wl_q) smp_l = in_data.range_mm;
		if (smp_ok && !left_side && in_data.range_mm < wr_q) smp_r = in_data.range_mm;
	end

	// shared add/shift unit
	logic signed [33:0] xs, ys;
	logic [4:0] sh;
	assign sh = 5'(step_q);
	assign xs = x_q >>> sh;
	assign ys = y_q >>> sh;

	// 16x32 partial product of magnitude times inverse gain
	logic [33:0] mag;
	logic [15:0] mpart;
	logic [47:0] pprod;
	assign mag = x_q[33] ? 34'd0 : x_q;
	always_comb begin
		case (mcnt_q)
			2'd0: mpart = mag[15:0];
			2'd1: mpart = mag[31:16];
			default: mpart = {14'd0, mag[33:32]};
		endcase
		pprod = mpart * INV_GAIN_Q32;
	end

	// divider trial: rem in [0,slowdown)
	logic [16:0] rtrial;
	assign rtrial = {rem_q, 1'b0};

	// heading degrees to binary angle: m*floor(2^32/360) + floor((256m+180)/360)
	logic [16:0] hstep;
	logic [8:0] hm;
	logic [31:0] hbase;
	logic [16:0] hfv;
	logic [34:0] hfp;
	logic [31:0] hbam;
	assign hstep = 17'd360 << hcnt_q;
	assign hm = hred_q[8:0];
	assign hbase = 32'(hm) * BAM_PER_DEG;
	assign hfv = {hm, 8'd0} + 17'd180;
	assign hfp = 35'(hfv) * RECIP_360;
	assign hbam = hbase + 32'(hfp[34:26]);

	// heading error and turn
	logic [31:0] err;
	logic signed [32:0] e33;
	logic signed [33:0] tsum;
	logic signed [17:0] tval;
	logic signed [15:0] tsat;
	always_comb begin
		err = z_q - head_bam_q;
		e33 = (err == 32'h80000000) ? 33'sh080000000 : 33'(signed'(err));
		tsum = 34'(e33) + 34'sd32768;
		tval = 18'(tsum >>> 16);
		if (tval > 18'sd32767) tsat = 16'sd32767;
		else if (tval < -18'sd32768) tsat = -16'sd32768;
		else tsat = 16'(tval);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			goal_e_q <= '0;
			goal_n_q <= '0;
			scan_len_q <= 13'd456;
			max_range_q <= 16'd10000;
			floor_q <= 16'd50;
			obst_q <= 16'd500;
			radius_q <= 16'd30;
			slowdown_q <= 16'd500;
			head_bam_q <= '0;
			wl_q <= 16'd10000;
			wr_q <= 16'd10000;
			lmin_q <= 16'd10000;
			rmin_q <= 16'd10000;
			obst_flag_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GOAL_E: goal_e_q <= cfg_data[26:0];
					REG_GOAL_N: goal_n_q <= cfg_data[29:0];
					REG_SCAN_LEN: scan_len_q <= cfg_data[12:0];
					REG_MAX_RANGE: max_range_q <= cfg_data[15:0];
					REG_FLOOR: floor_q <= cfg_data[15:0];
					REG_OBST: obst_q <= cfg_data[15:0];
					REG_RADIUS: radius_q <= cfg_data[15:0];
					REG_SLOWDOWN: slowdown_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_data.cmd)
							CMD_RANGE: begin
								if (in_data.last_sample) begin
									lmin_q <= smp_l;
									rmin_q <= smp_r;
									obst_flag_q <= (smp_l < obst_q) || (smp_r < obst_q);
									wl_q <= max_range_q;
									wr_q <= max_range_q;
									idx_q <= '0;
								end else begin
									wl_q <= smp_l;
									wr_q <= smp_r;
									if (idx_q != {INDEX_BITS{1'b1}}) idx_q <= idx_q + 1'b1;
								end
							end
							CMD_HEADING: begin
								hred_q <= 17'(signed'(in_data.heading_deg)) + HEAD_LIFT;
								hcnt_q <= 3'd7;
								state_q <= ST_HEAD;
							end
							CMD_FIX: begin
								x_q <= 34'(signed'({4'd0, goal_n_q}))
									- 34'(signed'({4'd0, in_data.northing_cm}));
								y_q <= 34'(signed'({7'd0, goal_e_q}))
									- 34'(signed'({7'd0, in_data.easting_cm}));
								state_q <= ST_PRE;
							end
							default: ;
						endcase
					end
				end
				ST_HEAD: begin
					// reduce mod 360 by subtracting 360*2^k, one k a cycle
					if (hred_q >= hstep) hred_q <= hred_q - hstep;
					if (hcnt_q == 3'd0) state_q <= ST_HBAM;
					else hcnt_q <= hcnt_q - 1'b1;
				end
				ST_HBAM: begin
					head_bam_q <= hbam;
					state_q <= ST_IDLE;
				end
				ST_PRE: begin
					if (x_q < 0) begin
						x_q <= -x_q;
						y_q <= -y_q;
						z_q <= 32'h80000000;
					end else begin
						z_q <= '0;
					end
					step_q <= '0;
					state_q <= ST_CORDIC;
				end
				ST_CORDIC: begin
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_bam(sh);
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_bam(sh);
					end
					if (step_q == STEP_BITS'(CORDIC_STEPS - 1)) begin
						state_q <= ST_MUL;
						mcnt_q <= '0;
						acc_q <= 64'h80000000;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (mcnt_q == 2'd3) begin
						logic [31:0] d;
						d = acc_q[63:32];
						dist_q <= (d > {2'd0, DIST_MAX}) ? DIST_MAX : d[29:0];
						rem_q <= '0;
						quo_q <= '0;
						dcnt_q <= '0;
						state_q <= ST_DIV;
					end else begin
						acc_q <= acc_q + (64'(pprod) << {mcnt_q, 4'd0});
						mcnt_q <= mcnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					// quotient of dist*32768 fits 16 bits when dist < slowdown, the only case that uses it
					logic [16:0] rn;
					logic [4:0] bi;
					bi = 5'd15 - dcnt_q;
					rn = rtrial | 17'((dcnt_q < 5'd16) ? dist_q[bi] : 1'b0);
					if (rn >= {1'b0, slowdown_q}) begin
						rem_q <= 16'(rn - {1'b0, slowdown_q});
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						rem_q <= rn[15:0];
						quo_q <= {quo_q[14:0], 1'b0};
					end
					if (dcnt_q == 5'd30) state_q <= ST_OUT;
					dcnt_q <= dcnt_q + 1'b1;
				end
				ST_OUT: begin
					// wait here while the previous result is still held
					if (out_load) begin
						if (dist_q < {14'd0, radius_q}) begin
							out_q.speed <= '0;
							out_q.turn <= '0;
							out_q.mode <= MODE_GOAL;
						end else if (obst_flag_q) begin
							out_q.speed <= SPEED_AVOID;
							out_q.turn <= (lmin_q < rmin_q) ? -TURN_AVOID : TURN_AVOID;
							out_q.mode <= MODE_AVOID;
						end else begin
							out_q.speed <= (dist_q >= {14'd0, slowdown_q}) ? SPEED_FULL
								: quo_q[14:0];
							out_q.turn <= tsat;
							out_q.mode <= MODE_STEER;
						end
						out_q.distance_cm <= dist_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
